// File: design/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define LCPD_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// antecedent at one edge implies consequent at the next edge
`define LCPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/lcpd_pkg.sv
// ----------------------------------------------------------------------------
// lcpd_pkg
// shared types and constants of the channel decoder
// ----------------------------------------------------------------------------
package lcpd_pkg;

    localparam int MAX_HEIGHT   = 4096;
    localparam int ROW_AW       = $clog2(MAX_HEIGHT);
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 13;

    localparam logic [24:0] PIXEL_CAP = 25'h100_0000;
    localparam logic [15:0] COMP_RAW      = 16'd0;
    localparam logic [15:0] COMP_PACKBITS = 16'd1;
    localparam logic [15:0] COMP_UNKNOWN  = 16'd33;
    localparam logic [7:0]  OPAQUE        = 8'hFF;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST    = 3'd3;

    localparam logic [1:0] LANE_ALPHA = 2'd0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_layer;
    } in_item_t;

    typedef struct packed {
        logic [23:0] pixel_index;
        logic [24:0] run_length;
        logic [7:0]  fill_value;
        logic [1:0]  lane;
    } out_item_t;

    // layer configuration seen by the decoder
    typedef struct packed {
        logic [12:0] width;
        logic [12:0] height;
        logic [4:0]  channels;
        logic        first;
        logic [24:0] total;
    } layer_cfg_t;

    // queue status toward the decoder
    typedef struct packed {
        logic valid;
        logic space;
    } queue_ctl_t;

endpackage

// File: design/lcpd_ram.sv
// ----------------------------------------------------------------------------
// lcpd_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module lcpd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/lcpd_front.sv
// ----------------------------------------------------------------------------
// lcpd_front
// two-entry input queue ahead of the decoder
// ----------------------------------------------------------------------------
module lcpd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  lcpd_pkg::in_item_t in_item,
    output lcpd_pkg::in_item_t head,
    output logic               head_valid,
    input  logic               take
);

    lcpd_pkg::in_item_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = take && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: design/lcpd_out_queue.sv
// ----------------------------------------------------------------------------
// lcpd_out_queue
// two-entry result queue behind the decoder
// ----------------------------------------------------------------------------
module lcpd_out_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  lcpd_pkg::out_item_t wr_item,
    output logic                space,
    output logic                empty,
    input  logic                pop,
    output lcpd_pkg::out_item_t result
);

    lcpd_pkg::out_item_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign space   = (count_reg != 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign result  = mem_reg[rd_ptr_reg];
    assign do_push = wr && space;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// File: design/lcpd_back.sv
// ----------------------------------------------------------------------------
// lcpd_back
// channel parse machine: compression word, row table, packets, fill commands
// ----------------------------------------------------------------------------
module lcpd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lcpd_pkg::layer_cfg_t cfg,
    input  lcpd_pkg::queue_ctl_t qctl,
    input  lcpd_pkg::in_item_t   item,
    output logic                 take,
    output logic                 out_wr,
    output lcpd_pkg::out_item_t  out_item
);

    typedef enum logic [3:0] {
        PH_COMP_HI, PH_COMP_LO, PH_RAW, PH_TAB_HI, PH_TAB_LO,
        PH_CTRL, PH_REP_VAL, PH_LIT, PH_DONE, PH_SKIP_ISSUE, PH_SKIP_WAIT
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] comp_reg, comp_next;
    logic [4:0]  ch_reg, ch_next;
    logic [12:0] row_reg, row_next;
    logic [15:0] cons_reg, cons_next;
    logic [7:0]  lit_reg, lit_next;
    logic [24:0] pos_reg, pos_next;
    logic [7:0]  held_reg, held_next;
    logic [15:0] cnt_reg, cnt_next;

    phase_t      ph;
    logic [7:0]  b;
    logic [5:0]  ch_inc;
    phase_t      ec_phase;
    logic        ec_zero_pos;
    logic [15:0] cons_bump;
    logic [25:0] adv_sum;
    logic [24:0] adv_len;
    logic [24:0] adv_pos;
    logic        e_req;
    logic [24:0] e_len;
    logic        is4;
    logic        alpha;
    logic        color_ok;
    logic [1:0]  e_lane;
    logic [24:0] room;
    logic        e_ok;
    logic        nl_emit;
    logic [13:0] row_inc;
    logic        pk_end;
    logic [7:0]  lit_dec;

    logic                            ram_we;
    logic                            ram_re;
    logic [lcpd_pkg::ROW_AW-1:0]     ram_addr_w;
    logic [lcpd_pkg::ROW_AW-1:0]     ram_addr_r;
    logic [15:0]                     ram_rdata;

    lcpd_ram #(
        .WIDTH (16),
        .DEPTH (lcpd_pkg::MAX_HEIGHT)
    ) u_row_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr_w),
        .wdata ({held_reg, b}),
        .re    (ram_re),
        .raddr (ram_addr_r),
        .rdata (ram_rdata)
    );

    assign ram_addr_w = row_reg[lcpd_pkg::ROW_AW-1:0];
    assign ram_addr_r = row_reg[lcpd_pkg::ROW_AW-1:0];

    assign take = qctl.valid && qctl.space
               && (phase_reg != PH_SKIP_ISSUE) && (phase_reg != PH_SKIP_WAIT);
    assign b    = item.data_byte;
    assign ph   = item.new_layer ? PH_COMP_HI : phase_reg;

    always_comb
    begin
        comp_next = (take && ph == PH_COMP_LO) ? {held_reg, b} : comp_reg;

        // end of channel, with the shared raw word rule folded in
        ch_inc = {1'b0, ch_reg} + 6'd1;
        ec_zero_pos = 1'b0;
        if (ch_inc >= {1'b0, cfg.channels})
        begin
            ec_phase = PH_DONE;
        end
        else if (cfg.first && comp_next == lcpd_pkg::COMP_RAW)
        begin
            ec_zero_pos = 1'b1;
            ec_phase = (cfg.total != 25'd0) ? PH_RAW : PH_DONE;
        end
        else
        begin
            ec_phase = PH_COMP_HI;
        end

        cons_bump = (cons_reg == 16'hFFFF) ? cons_reg : cons_reg + 16'd1;
        lit_dec   = (lit_reg != 8'd0) ? lit_reg - 8'd1 : lit_reg;
        row_inc   = {1'b0, row_reg} + 14'd1;

        phase_next = phase_reg;
        ch_next    = ch_reg;
        row_next   = row_reg;
        cons_next  = cons_reg;
        lit_next   = lit_reg;
        pos_next   = pos_reg;
        held_next  = held_reg;
        cnt_next   = cnt_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        e_req      = 1'b0;
        e_len      = 25'd1;
        adv_len    = 25'd1;
        pk_end     = 1'b0;
        nl_emit    = 1'b0;

        if (take && item.new_layer)
        begin
            ch_next   = 5'd0;
            row_next  = 13'd0;
            cons_next = 16'd0;
            lit_next  = 8'd0;
            pos_next  = 25'd0;
            nl_emit   = (cfg.channels < 5'd4) && (cfg.total != 25'd0);
        end

        if (take)
        begin
            case (ph)
                PH_COMP_HI:
                begin
                    held_next  = b;
                    phase_next = PH_COMP_LO;
                end
                PH_COMP_LO:
                begin
                    if (comp_next == lcpd_pkg::COMP_RAW)
                    begin
                        pos_next = 25'd0;
                        if (cfg.total == 25'd0)
                        begin
                            phase_next = ec_phase;
                            ch_next    = ch_inc[4:0];
                        end
                        else
                        begin
                            phase_next = PH_RAW;
                        end
                    end
                    else if (comp_next == lcpd_pkg::COMP_PACKBITS)
                    begin
                        row_next = 13'd0;
                        pos_next = 25'd0;
                        if (cfg.height == 13'd0)
                        begin
                            phase_next = ec_phase;
                            ch_next    = ch_inc[4:0];
                        end
                        else
                        begin
                            phase_next = PH_TAB_HI;
                        end
                    end
                    else
                    begin
                        phase_next = ec_phase;
                        ch_next    = ch_inc[4:0];
                        if (ec_zero_pos)
                        begin
                            pos_next = 25'd0;
                        end
                    end
                end
                PH_RAW:
                begin
                    e_req    = 1'b1;
                    pos_next = adv_pos;
                    if (adv_pos >= cfg.total)
                    begin
                        phase_next = ec_phase;
                        ch_next    = ch_inc[4:0];
                        if (ec_zero_pos)
                        begin
                            pos_next = 25'd0;
                        end
                    end
                end
                PH_TAB_HI:
                begin
                    held_next  = b;
                    phase_next = PH_TAB_LO;
                end
                PH_TAB_LO:
                begin
                    ram_we = (row_reg[12:lcpd_pkg::ROW_AW] == '0);
                    if (row_inc >= {1'b0, cfg.height})
                    begin
                        row_next   = 13'd0;
                        phase_next = PH_SKIP_ISSUE;
                    end
                    else
                    begin
                        row_next   = row_inc[12:0];
                        phase_next = PH_TAB_HI;
                    end
                end
                PH_CTRL:
                begin
                    cons_next = cons_bump;
                    if (b[7])
                    begin
                        lit_next   = 8'd1 - b;
                        phase_next = PH_REP_VAL;
                    end
                    else
                    begin
                        lit_next   = b + 8'd1;
                        phase_next = PH_LIT;
                    end
                end
                PH_REP_VAL:
                begin
                    cons_next = cons_bump;
                    e_req     = 1'b1;
                    e_len     = {17'd0, lit_reg};
                    adv_len   = {17'd0, lit_reg};
                    pos_next  = adv_pos;
                    lit_next  = 8'd0;
                    pk_end    = 1'b1;
                end
                PH_LIT:
                begin
                    cons_next = cons_bump;
                    e_req     = 1'b1;
                    pos_next  = adv_pos;
                    lit_next  = lit_dec;
                    pk_end    = (lit_dec == 8'd0);
                    if (!pk_end)
                    begin
                        phase_next = PH_LIT;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            if (pk_end)
            begin
                if (cons_bump >= cnt_reg)
                begin
                    row_next   = row_inc[12:0];
                    phase_next = PH_SKIP_ISSUE;
                end
                else
                begin
                    phase_next = PH_CTRL;
                end
            end
        end
        else
        begin
            // row search through the table, each lookup issued in PH_SKIP_ISSUE and read in PH_SKIP_WAIT
            case (phase_reg)
                PH_SKIP_ISSUE:
                begin
                    cons_next = 16'd0;
                    if (row_reg >= cfg.height)
                    begin
                        phase_next = ec_phase;
                        ch_next    = ch_inc[4:0];
                        if (ec_zero_pos)
                        begin
                            pos_next = 25'd0;
                        end
                    end
                    else if (row_reg[12:lcpd_pkg::ROW_AW] != '0)
                    begin
                        row_next = row_inc[12:0];
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        phase_next = PH_SKIP_WAIT;
                    end
                end
                PH_SKIP_WAIT:
                begin
                    if (ram_rdata == 16'd0)
                    begin
                        row_next   = row_inc[12:0];
                        phase_next = PH_SKIP_ISSUE;
                    end
                    else
                    begin
                        cnt_next   = ram_rdata;
                        phase_next = PH_CTRL;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // pixel advance saturating at the store size
    always_comb
    begin
        adv_sum = {1'b0, pos_reg} + {1'b0, adv_len};
        adv_pos = (adv_sum > {1'b0, lcpd_pkg::PIXEL_CAP}) ? lcpd_pkg::PIXEL_CAP
                                                          : adv_sum[24:0];
    end

    // lane choice and clipping of a fill
    always_comb
    begin
        is4      = (cfg.channels == 5'd4);
        alpha    = is4 && (ch_reg == 5'd0);
        color_ok = is4 ? (ch_reg >= 5'd1 && ch_reg <= 5'd3) : (ch_reg <= 5'd2);
        e_lane   = alpha ? lcpd_pkg::LANE_ALPHA
                 : (is4 ? ch_reg[1:0] : ch_reg[1:0] + 2'd1);
        room     = cfg.total - pos_reg;
        e_ok     = e_req && (alpha ? (b != 8'd0) : color_ok)
                && (pos_reg < cfg.total) && (e_len != 25'd0);
        out_wr   = take && (nl_emit || e_ok);
        if (nl_emit)
        begin
            out_item.pixel_index = 24'd0;
            out_item.run_length  = cfg.total;
            out_item.fill_value  = lcpd_pkg::OPAQUE;
            out_item.lane        = lcpd_pkg::LANE_ALPHA;
        end
        else
        begin
            out_item.pixel_index = pos_reg[23:0];
            out_item.run_length  = (e_len > room) ? room : e_len;
            out_item.fill_value  = b;
            out_item.lane        = e_lane;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_COMP_HI;
            comp_reg  <= lcpd_pkg::COMP_UNKNOWN;
            ch_reg    <= 5'd0;
            row_reg   <= 13'd0;
            cons_reg  <= 16'd0;
            lit_reg   <= 8'd0;
            pos_reg   <= 25'd0;
            held_reg  <= 8'd0;
            cnt_reg   <= 16'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            comp_reg  <= comp_next;
            ch_reg    <= ch_next;
            row_reg   <= row_next;
            cons_reg  <= cons_next;
            lit_reg   <= lit_next;
            pos_reg   <= pos_next;
            held_reg  <= held_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: design/layer_channel_packbits_decoder_unit.sv
// path: a byte is registered in the input queue and its result in the result queue
// throughput: one byte per cycle unless the result queue is full or a packbits row search runs;
//   each row table entry scanned needs an issue and a wait step for the registered ram read
// reset: rst_n resets control state and configuration at once; the row table
//   is not cleared, its entries are written by each channel's table
// ----------------------------------------------------------------------------
// layer_channel_packbits_decoder_unit
// decodes a layer's raw/packbits channel stream into argb byte-lane fills
// ----------------------------------------------------------------------------
module layer_channel_packbits_decoder_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input queue side
    input  logic                                 push,
    output logic                                 full,
    input  lcpd_pkg::in_item_t                   in_item,
    // result queue side
    output logic                                 empty,
    input  logic                                 pop,
    output lcpd_pkg::out_item_t                  result,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lcpd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lcpd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [12:0] width_reg, width_next;
    logic [12:0] height_reg, height_next;
    logic [4:0]  chans_reg, chans_next;
    logic        first_reg, first_next;
    logic [24:0] total_reg, total_next;
    logic [25:0] area;

    lcpd_pkg::layer_cfg_t cfg;
    lcpd_pkg::queue_ctl_t qctl;
    lcpd_pkg::in_item_t   head;
    lcpd_pkg::out_item_t  dec_item;
    logic                 head_valid;
    logic                 take;
    logic                 dec_wr;
    logic                 out_space;

    // configuration port never stalls
    assign cfg_ready = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        chans_next  = chans_reg;
        first_next  = first_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                lcpd_pkg::REG_WIDTH:    width_next  = cfg_data;
                lcpd_pkg::REG_HEIGHT:   height_next = cfg_data;
                lcpd_pkg::REG_CHANNELS: chans_next  = cfg_data[4:0];
                lcpd_pkg::REG_FIRST:    first_next  = cfg_data[0];
                default:                width_next  = width_reg;
            endcase
        end
        // pixel count of the layer, saturated at the store size
        area       = width_reg * height_reg;
        total_next = (area > {1'b0, lcpd_pkg::PIXEL_CAP}) ? lcpd_pkg::PIXEL_CAP
                                                         : area[24:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd0;
            height_reg <= 13'd0;
            chans_reg  <= 5'd0;
            first_reg  <= 1'b1;
            total_reg  <= 25'd0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            chans_reg  <= chans_next;
            first_reg  <= first_next;
            total_reg  <= total_next;
        end
    end

    assign cfg.width    = width_reg;
    assign cfg.height   = height_reg;
    assign cfg.channels = chans_reg;
    assign cfg.first    = first_reg;
    assign cfg.total    = total_reg;

    assign qctl.valid = head_valid;
    assign qctl.space = out_space;

    // front: byte queue
    lcpd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_item    (in_item),
        .head       (head),
        .head_valid (head_valid),
        .take       (take)
    );

    // back: parse machine with row table
    lcpd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .qctl     (qctl),
        .item     (head),
        .take     (take),
        .out_wr   (dec_wr),
        .out_item (dec_item)
    );

    // fill commands wait here for the pixel store
    lcpd_out_queue u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (dec_wr),
        .wr_item (dec_item),
        .space   (out_space),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

// File: design/lcpd_checker.sv
// ----------------------------------------------------------------------------
// lcpd_checker
// port-level checks of the channel decoder
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcpd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input lcpd_pkg::out_item_t result,
    input logic                cfg_ready
);

    logic [25:0] fill_end;
    logic        zero_alpha;

    assign fill_end   = {2'b00, result.pixel_index} + {1'b0, result.run_length};
    assign zero_alpha = (result.lane == lcpd_pkg::LANE_ALPHA) && (result.fill_value == 8'd0);

    `LCPD_ASSERT_ALWAYS(a_cfg_ready, clk, rst_n, cfg_ready)
    `LCPD_ASSERT_ALWAYS(a_no_zero_alpha, clk, rst_n, empty || !zero_alpha)
    `LCPD_ASSERT_ALWAYS(a_run_nonzero, clk, rst_n, empty || result.run_length != 25'd0)
    `LCPD_ASSERT_ALWAYS(a_in_store, clk, rst_n, empty || fill_end <= {1'b0, lcpd_pkg::PIXEL_CAP})
    `LCPD_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(result))

endmodule

bind layer_channel_packbits_decoder_unit lcpd_checker u_lcpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_ready (cfg_ready)
);
